### rtl/dkc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Digit-key shift cipher package
// Widths, register indexes and character bounds that the design and the
// checkers share, and the decimal thresholds of the key logic.
// ----------------------------------------------------------------------------
package dkc_pkg;

  localparam int unsigned KEY_NUMBER_W = 31;
  localparam int unsigned LINE_COUNT_W = 32;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned KEY_LEN_W    = 4;
  localparam int unsigned DIGIT_W      = 4;
  localparam int unsigned STEP_CNT_W   = 5;
  localparam int unsigned NUM_POW10    = 9;

  localparam logic [CHAR_W-1:0]  CHAR_LOW     = 8'h61;
  localparam logic [CHAR_W-1:0]  CHAR_HIGH    = 8'h7a;
  localparam logic [CHAR_W:0]    ALPHABET_LEN = 9'd26;
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

  localparam logic [LINE_COUNT_W-1:0] POW10 [NUM_POW10] = '{
    32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
    32'd10000000, 32'd100000000, 32'd1000000000
  };

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_NUMBER = 2'd0,
    REG_LINE_COUNT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic                 busy;
    logic                 reload;
    logic [KEY_LEN_W-1:0] len;
    logic [KEY_LEN_W-1:0] reload_len;
  } key_ctrl_t;

endpackage

`default_nettype wire

### rtl/digit_key_shift_cipher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Digit-key shift cipher
// Byte-stream cipher that shifts lowercase letters by a cycling decimal key.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_stall_o   in_char_i, last_of_message_i
// output    out        out_valid_o / out_stall_i out_char_o, out_last_o
// config    in         cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// One item is accepted per cycle unless stalled; its result is registered.
// A write to the key number or line count register starts the decimal
// conversion of the key number; its shift steps and load step stall input.
// Reset sets a key of length one with digit zero; no clearing pass follows.
// Apart from a key rebuild, the input stalls only while the result register
// holds an item that is stalled at the output.
// ----------------------------------------------------------------------------
module digit_key_shift_cipher
  import dkc_pkg::*;
#(
  parameter int unsigned MAX_KEY_DIGITS = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [CHAR_W-1:0]      in_char_i,
  input  wire logic                   last_of_message_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic      [CHAR_W-1:0]      out_char_o,
  output logic                        out_last_o
);

  logic [DIGIT_W-1:0] digits [MAX_KEY_DIGITS];
  key_ctrl_t          key_ctrl;

  dkc_key_gen #(
    .MAX_KEY_DIGITS(MAX_KEY_DIGITS)
  ) u_key_gen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .digits_o   (digits),
    .ctrl_o     (key_ctrl)
  );

  dkc_cipher #(
    .MAX_KEY_DIGITS(MAX_KEY_DIGITS)
  ) u_cipher (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_char_i        (in_char_i),
    .last_of_message_i(last_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_char_o       (out_char_o),
    .out_last_o       (out_last_o),
    .digits_i         (digits),
    .ctrl_i           (key_ctrl)
  );

endmodule

`default_nettype wire

### rtl/dkc_key_gen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Key generator
// Holds the configuration registers and converts the key number to decimal
// digits with a one-bit-per-cycle shift-and-add-3 converter.
// ----------------------------------------------------------------------------
module dkc_key_gen
  import dkc_pkg::*;
#(
  parameter int unsigned MAX_KEY_DIGITS = 10
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic      [DIGIT_W-1:0]      digits_o [MAX_KEY_DIGITS],
  output key_ctrl_t                    ctrl_o
);

  localparam logic [KEY_LEN_W-1:0] LEN_CAP = KEY_LEN_W'(MAX_KEY_DIGITS);

  logic [KEY_NUMBER_W-1:0] key_number_q, key_number_d;
  logic [LINE_COUNT_W-1:0] line_count_q, line_count_d;
  logic [KEY_NUMBER_W-1:0] shift_q, shift_d;
  logic [STEP_CNT_W-1:0]   cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic [KEY_LEN_W-1:0]    len_q, len_d;
  logic [DIGIT_W-1:0]      bcd_q [MAX_KEY_DIGITS];
  logic [DIGIT_W-1:0]      bcd_d [MAX_KEY_DIGITS];
  logic [DIGIT_W-1:0]      adj [MAX_KEY_DIGITS];
  logic [DIGIT_W-1:0]      bcd_step [MAX_KEY_DIGITS];
  logic [KEY_LEN_W-1:0]    count_len;
  logic                    write_hit;
  logic                    reload;

  assign write_hit = cfg_we_i &&
                     (cfg_index_i == REG_KEY_NUMBER || cfg_index_i == REG_LINE_COUNT);
  assign reload    = busy_q && (cnt_q == '0);

  always_comb begin
    logic [KEY_LEN_W-1:0] n;
    n = KEY_LEN_W'(1);
    for (int k = 0; k < NUM_POW10; k++) begin
      if (line_count_q >= POW10[k]) begin
        n = n + KEY_LEN_W'(1);
      end
    end
    count_len = (n > LEN_CAP) ? LEN_CAP : n;
  end

  always_comb begin
    for (int i = 0; i < MAX_KEY_DIGITS; i++) begin
      adj[i] = (bcd_q[i] >= DABBLE_LIMIT) ? bcd_q[i] + DABBLE_ADD : bcd_q[i];
    end
    bcd_step[0] = {adj[0][DIGIT_W-2:0], shift_q[KEY_NUMBER_W-1]};
    for (int i = 1; i < MAX_KEY_DIGITS; i++) begin
      bcd_step[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
    end
  end

  always_comb begin
    key_number_d = key_number_q;
    line_count_d = line_count_q;
    shift_d      = shift_q;
    cnt_d        = cnt_q;
    busy_d       = busy_q;
    len_d        = len_q;
    bcd_d        = bcd_q;
    if (write_hit) begin
      if (cfg_index_i == REG_KEY_NUMBER) begin
        key_number_d = cfg_wdata_i[KEY_NUMBER_W-1:0];
        shift_d      = cfg_wdata_i[KEY_NUMBER_W-1:0];
      end else begin
        line_count_d = cfg_wdata_i[LINE_COUNT_W-1:0];
        shift_d      = key_number_q;
      end
      cnt_d  = STEP_CNT_W'(KEY_NUMBER_W);
      busy_d = 1'b1;
      for (int i = 0; i < MAX_KEY_DIGITS; i++) begin
        bcd_d[i] = '0;
      end
    end else if (reload) begin
      busy_d = 1'b0;
      len_d  = count_len;
    end else if (busy_q) begin
      bcd_d   = bcd_step;
      shift_d = {shift_q[KEY_NUMBER_W-2:0], 1'b0};
      cnt_d   = cnt_q - STEP_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_number_q <= '0;
      line_count_q <= '0;
      shift_q      <= '0;
      cnt_q        <= '0;
      busy_q       <= 1'b0;
      len_q        <= KEY_LEN_W'(1);
      for (int i = 0; i < MAX_KEY_DIGITS; i++) begin
        bcd_q[i] <= '0;
      end
    end else begin
      key_number_q <= key_number_d;
      line_count_q <= line_count_d;
      shift_q      <= shift_d;
      cnt_q        <= cnt_d;
      busy_q       <= busy_d;
      len_q        <= len_d;
      bcd_q        <= bcd_d;
    end
  end

  assign digits_o          = bcd_q;
  assign ctrl_o.busy       = busy_q;
  assign ctrl_o.reload     = reload;
  assign ctrl_o.len        = len_q;
  assign ctrl_o.reload_len = count_len;

endmodule

`default_nettype wire

### rtl/dkc_cipher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cipher datapath
// Shifts lowercase letters by the current key digit, passes other bytes
// unchanged into the result register, and steps the key position.
// ----------------------------------------------------------------------------
module dkc_cipher
  import dkc_pkg::*;
#(
  parameter int unsigned MAX_KEY_DIGITS = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [CHAR_W-1:0]  in_char_i,
  input  wire logic               last_of_message_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [CHAR_W-1:0]  out_char_o,
  output logic                    out_last_o,
  input  wire logic [DIGIT_W-1:0] digits_i [MAX_KEY_DIGITS],
  input  wire key_ctrl_t          ctrl_i
);

  localparam int unsigned IDX_W = (MAX_KEY_DIGITS > 1) ? $clog2(MAX_KEY_DIGITS) : 1;

  logic [KEY_LEN_W-1:0] idx_q, idx_d;
  logic                 out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]    out_char_q, out_char_d;
  logic                 out_last_q, out_last_d;
  logic                 accept;
  logic [DIGIT_W-1:0]   digit;
  logic [CHAR_W:0]      sum;
  logic [CHAR_W-1:0]    ciphered;

  assign in_stall_o = ctrl_i.busy || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign digit      = digits_i[idx_q[IDX_W-1:0]];

  always_comb begin
    sum      = {1'b0, in_char_i} + {{(CHAR_W + 1 - DIGIT_W){1'b0}}, digit};
    ciphered = in_char_i;
    if (in_char_i >= CHAR_LOW && in_char_i <= CHAR_HIGH) begin
      if (sum > {1'b0, CHAR_HIGH}) begin
        sum = sum - ALPHABET_LEN;
      end
      ciphered = sum[CHAR_W-1:0];
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (ctrl_i.reload) begin
      idx_d = ctrl_i.reload_len - KEY_LEN_W'(1);
    end else if (accept) begin
      if (last_of_message_i || idx_q == '0) begin
        idx_d = ctrl_i.len - KEY_LEN_W'(1);
      end else begin
        idx_d = idx_q - KEY_LEN_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (!out_valid_q || !out_stall_i) begin
      out_valid_d = accept;
    end
    if (accept) begin
      out_char_d = ciphered;
      out_last_d = last_of_message_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

### rtl/dkc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Digit-key shift cipher checker
// Port-level properties of the cipher, bound to the top level.
// ----------------------------------------------------------------------------
module dkc_checker
  import dkc_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   cfg_we_i,
  input wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input wire logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_o,
  input wire logic [CHAR_W-1:0]      in_char_i,
  input wire logic                   last_of_message_i,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic [CHAR_W-1:0]      out_char_o,
  input wire logic                   out_last_o
);

  logic in_acc;
  logic in_letter;
  logic cfg_hit;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_letter = (in_char_i >= CHAR_LOW) && (in_char_i <= CHAR_HIGH);
  assign cfg_hit   = cfg_we_i && (cfg_index_i == REG_KEY_NUMBER ||
                                  cfg_index_i == REG_LINE_COUNT) &&
                     (cfg_wdata_i == cfg_wdata_i);

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Stalled result was dropped.");

  a_last_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o && (out_last_o == $past(last_of_message_i)))
    else $error("Accepted item did not appear with its last flag.");

  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_letter |=> out_char_o == $past(in_char_i))
    else $error("Non-letter byte was altered.");

  a_letter_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_letter |=> (out_char_o >= CHAR_LOW) && (out_char_o <= CHAR_HIGH))
    else $error("Letter left the lowercase range.");

  a_cfg_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> in_stall_o)
    else $error("Input was not stalled while the key is rebuilt.");

endmodule

bind digit_key_shift_cipher dkc_checker u_dkc_checker (.*);

`default_nettype wire

### dv/cipher_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Digit-key cipher stream checker
// Watches the register port and both byte channels, keeps its own copy of the
// key, predicts the ciphered byte of every accepted item and compares it with
// the oldest outstanding prediction when a result is accepted.
// ----------------------------------------------------------------------------
module cipher_stream_checker
  import dkc_pkg::*;
#(
  parameter int unsigned MAX_KEY_DIGITS = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_stall_i,
  input  wire logic [CHAR_W-1:0]      in_char_i,
  input  wire logic                   last_of_message_i,
  input  wire logic                   out_valid_i,
  input  wire logic                   out_stall_i,
  input  wire logic [CHAR_W-1:0]      out_char_i,
  input  wire logic                   out_last_i,
  output int unsigned                 fail_cnt_o,
  output int unsigned                 pending_o,
  output int unsigned                 checked_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } cipher_byte_t;

  cipher_byte_t ciphered_q [$];

  logic [KEY_NUMBER_W-1:0] key_number_q;
  logic [LINE_COUNT_W-1:0] line_count_q;
  logic [DIGIT_W-1:0]      key_digit_q [MAX_KEY_DIGITS];
  logic [KEY_LEN_W-1:0]    key_len_q;
  logic [KEY_LEN_W-1:0]    key_pos_q;

  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned checked_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = pending_cnt;
  assign checked_o  = checked_cnt;

  // The key length is the decimal digit count of the line count, and the key
  // is the low digits of the key number, most significant first.
  function automatic void load_key();
    int unsigned       n;
    longint unsigned   p;
    longint unsigned   k;
    n = 1;
    p = 10;
    k = 64'(key_number_q);
    while (n < 10 && longint'(line_count_q) >= p) begin
      n++;
      p *= 10;
    end
    if (n > MAX_KEY_DIGITS) begin
      n = MAX_KEY_DIGITS;
    end
    for (int i = 0; i < MAX_KEY_DIGITS; i++) begin
      key_digit_q[i] = '0;
    end
    for (int i = n; i > 0; i--) begin
      key_digit_q[i-1] = DIGIT_W'(k % 10);
      k = k / 10;
    end
    key_len_q = KEY_LEN_W'(n);
    key_pos_q = '0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_check
    cipher_byte_t         want;
    cipher_byte_t         got;
    logic [CHAR_W:0]      shifted;
    logic [KEY_LEN_W-1:0] pos;
    if (!rst_ni) begin
      ciphered_q.delete();
      key_number_q = '0;
      line_count_q = '0;
      load_key();
      fail_cnt    = 0;
      pending_cnt = 0;
      checked_cnt = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_KEY_NUMBER) begin
          key_number_q = cfg_wdata_i[KEY_NUMBER_W-1:0];
          load_key();
        end else if (cfg_index_i == REG_LINE_COUNT) begin
          line_count_q = cfg_wdata_i[LINE_COUNT_W-1:0];
          load_key();
        end
      end

      if (in_valid_i && !in_stall_i) begin
        pos = (key_pos_q >= key_len_q) ? '0 : key_pos_q;
        shifted = {1'b0, in_char_i};
        if (in_char_i >= CHAR_LOW && in_char_i <= CHAR_HIGH) begin
          shifted = shifted + (CHAR_W + 1)'(key_digit_q[pos]);
          if (shifted > {1'b0, CHAR_HIGH}) begin
            shifted = shifted - ALPHABET_LEN;
          end
        end
        want.ch   = shifted[CHAR_W-1:0];
        want.last = last_of_message_i;
        ciphered_q.push_back(want);
        pos = pos + KEY_LEN_W'(1);
        if (pos >= key_len_q || last_of_message_i) begin
          pos = '0;
        end
        key_pos_q = pos;
      end

      if (out_valid_i && !out_stall_i) begin
        got.ch   = out_char_i;
        got.last = out_last_i;
        if (ciphered_q.size() == 0) begin
          if (fail_cnt < 10) begin
            $display("%0t: result %02h last %0b with no item waiting",
                     $realtime, got.ch, got.last);
          end
          fail_cnt++;
        end else begin
          want = ciphered_q.pop_front();
          checked_cnt++;
          if (got.ch !== want.ch || got.last !== want.last) begin
            if (fail_cnt < 10) begin
              $display("%0t: out_char %02h out_last %0b, expected %02h %0b",
                       $realtime, got.ch, got.last, want.ch, want.last);
            end
            fail_cnt++;
          end
        end
      end
      pending_cnt = ciphered_q.size();
    end
  end

endmodule

### dv/tb_digit_key_shift_cipher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Digit-key shift cipher testbench
// Drives byte messages through the cipher under several key settings and
// flow-control patterns, and lets the stream checker judge every result.
// ----------------------------------------------------------------------------
module tb_digit_key_shift_cipher;
  import dkc_pkg::*;

  localparam int unsigned MAX_KEY_DIGITS  = 10;
  localparam int unsigned ITEMS_PER_PHASE = 470;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                   clk_i             = 1'b0;
  logic                   rst_ni            = 1'b0;
  logic                   cfg_we_i          = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i       = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i       = '0;
  logic                   in_valid_i        = 1'b0;
  logic                   in_stall_o;
  logic [CHAR_W-1:0]      in_char_i         = '0;
  logic                   last_of_message_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i       = 1'b0;
  logic [CHAR_W-1:0]      out_char_o;
  logic                   out_last_o;

  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned checked_cnt;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent     = 0;
  int unsigned reg_writes     = 0;
  int unsigned quiet_cycles   = 0;

  always #1 clk_i = ~clk_i;

  digit_key_shift_cipher #(
    .MAX_KEY_DIGITS(MAX_KEY_DIGITS)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .in_char_i,
    .last_of_message_i,
    .out_valid_o,
    .out_stall_i,
    .out_char_o,
    .out_last_o
  );

  cipher_stream_checker #(
    .MAX_KEY_DIGITS(MAX_KEY_DIGITS)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_i        (in_stall_o),
    .in_char_i,
    .last_of_message_i,
    .out_valid_i       (out_valid_o),
    .out_stall_i,
    .out_char_i        (out_char_o),
    .out_last_i        (out_last_o),
    .fail_cnt_o        (fail_cnt),
    .pending_o         (pending_cnt),
    .checked_o         (checked_cnt)
  );

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_digit_key_shift_cipher NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // All tasks below start and end at a falling clock edge.
  task automatic send_item(input logic [CHAR_W-1:0] ch, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_char_i         <= ch;
    last_of_message_i <= last;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_cnt != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    reg_writes++;
    while (in_stall_o) begin
      @(negedge clk_i);
    end
  endtask

  task automatic set_key(input logic [CFG_DATA_W-1:0] key_number,
                         input logic [CFG_DATA_W-1:0] line_count);
    wait_drained();
    write_reg(REG_KEY_NUMBER, key_number);
    write_reg(REG_LINE_COUNT, line_count);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_line_count();
    int unsigned     d;
    longint unsigned lo;
    longint unsigned hi;
    d  = $urandom_range(1, 10);
    lo = 1;
    repeat (d - 1) lo *= 10;
    hi = lo * 10 - 1;
    if (hi > 64'hFFFF_FFFF) begin
      hi = 64'hFFFF_FFFF;
    end
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return ($urandom_range(1) != 0) ? CFG_DATA_W'(lo) : CFG_DATA_W'(lo - 1);
      default: return CFG_DATA_W'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_key_number();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 32'h7FFF_FFFF;
      2:       return '1;
      3:       return $urandom_range(999);
      default: return $urandom;
    endcase
  endfunction

  task automatic change_key();
    wait_drained();
    case ($urandom_range(3))
      0:       write_reg(REG_KEY_NUMBER, pick_key_number());
      1:       write_reg(REG_LINE_COUNT, pick_line_count());
      default: begin
        write_reg(REG_KEY_NUMBER, pick_key_number());
        write_reg(REG_LINE_COUNT, pick_line_count());
      end
    endcase
    if ($urandom_range(3) == 0) begin
      write_reg(($urandom_range(1) != 0) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
    end
  endtask

  task automatic send_message();
    int unsigned       len;
    int unsigned       r;
    logic              broken;
    logic [CHAR_W-1:0] ch;
    len    = $urandom_range(1, 14);
    broken = ($urandom_range(9) == 0);
    for (int j = 0; j < len; j++) begin
      r = $urandom_range(99);
      if (r < 55) begin
        ch = CHAR_LOW + CHAR_W'($urandom_range(25));
      end else if (r < 70) begin
        ch = CHAR_HIGH - CHAR_W'($urandom_range(4));
      end else if (r < 78) begin
        ch = ($urandom_range(1) != 0) ? CHAR_LOW - CHAR_W'(1) : CHAR_HIGH + CHAR_W'(1);
      end else begin
        ch = CHAR_W'($urandom_range(255));
      end
      send_item(ch, broken ? 1'($urandom_range(1)) : (j == len - 1));
    end
  endtask

  initial begin
    int unsigned next_change;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 34 : (ph == 1) ? 48 : 0;
      recv_stall_pct = (ph == 0) ? 48 : (ph == 1) ? 34 : 0;

      if (ph == 0) begin
        // The reset key is a single zero digit, so every byte passes as is.
        send_item(CHAR_LOW, 1'b0);
        send_item(CHAR_HIGH, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);

        // Ten-digit key from the largest values; the eleventh byte reuses the
        // first digit.
        set_key('1, '1);
        repeat (10) send_item(CHAR_HIGH, 1'b0);
        send_item(CHAR_HIGH - CHAR_W'(1), 1'b1);

        // Short key number: the leading digits of the key are zero.
        set_key(32'd7, 32'd12345);
        send_item(CHAR_LOW - CHAR_W'(1), 1'b0);
        send_item(CHAR_HIGH + CHAR_W'(1), 1'b0);
        send_item(CHAR_LOW, 1'b0);

        // A write to an unused index must leave the key position alone.
        wait_drained();
        write_reg(REG_SPARE_2, $urandom);
        send_item(CHAR_HIGH, 1'b0);
        send_item(CHAR_HIGH, 1'b1);
      end

      next_change = items_sent + $urandom_range(60, 160);
      while (items_sent < (ph + 1) * ITEMS_PER_PHASE) begin
        send_message();
        if (items_sent >= next_change) begin
          change_key();
          next_change = items_sent + $urandom_range(60, 160);
        end
      end
    end

    wait_drained();
    repeat (4) @(negedge clk_i);
    $display("Ciphered %0d bytes under %0d register writes; %0d results checked.",
             items_sent, reg_writes, checked_cnt);
    $display("Flow control ran with sender and receiver gaps, swapped, then none.");
    if (fail_cnt == 0) begin
      $display("tb_digit_key_shift_cipher OK");
    end else begin
      $display("tb_digit_key_shift_cipher NOT OK");
    end
    $finish;
  end

endmodule
